// ----- sv/dpt_pkg.sv -----
// shared types and constants of the device presence table
// no dependencies; imported by every module of the block
package dpt_pkg;

    localparam int DEF_TABLE_ENTRIES = 32;
    localparam int SLOT_W            = 5;
    localparam int ID_W              = 32;
    localparam int ADDR_W            = 32;
    localparam int PORT_W            = 16;
    localparam int TIME_W            = 32;
    localparam int TIMEOUT_W         = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

    // function codes carried on the input tuser
    localparam logic FUNC_LOOKUP   = 1'b0;
    localparam logic FUNC_REGISTER = 1'b1;

    // one table record
    typedef struct packed {
        logic [ID_W-1:0]   id_high;
        logic [ID_W-1:0]   id_low;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] stamp;
    } rec_t;

    // verdict of the compare unit for one record
    typedef struct packed {
        logic reg_hit;   // slot may take a register transfer
        logic look_hit;  // slot answers a lookup
        logic online;    // age below timeout
    } match_t;

endpackage

// ----- sv/dpt_store.sv -----
// record memory of the device presence table, one write and one read port
// read data registered; depends on dpt_pkg
module dpt_store #(
    parameter int DEPTH = dpt_pkg::DEF_TABLE_ENTRIES,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_addr,
    input  dpt_pkg::rec_t      wr_data,
    input  logic [IDX_W-1:0]   rd_addr,
    output dpt_pkg::rec_t      rd_data
);
    import dpt_pkg::*;

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/dpt_match.sv -----
// shared compare unit: id equality, age subtract and timeout compares
// for the one record read per cycle; depends on dpt_pkg
module dpt_match (
    input  dpt_pkg::rec_t                         rec,
    input  logic [dpt_pkg::ID_W-1:0]              id_high,
    input  logic [dpt_pkg::ID_W-1:0]              id_low,
    input  logic [dpt_pkg::TIME_W-1:0]            now_secs,
    input  logic [dpt_pkg::TIMEOUT_W-1:0]         timeout,
    output dpt_pkg::match_t                       verdict
);
    import dpt_pkg::*;

    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] timeout_ext;
    logic              id_eq;
    logic              empty;

    // age wraps modulo 2^32, so a future stamp reads as very old
    assign age         = now_secs - rec.stamp;
    assign timeout_ext = TIME_W'(timeout);
    assign id_eq       = (rec.id_high == id_high) && (rec.id_low == id_low);
    assign empty       = (rec.stamp == '0);

    assign verdict.reg_hit  = empty || (age > timeout_ext) || id_eq;
    assign verdict.look_hit = !empty && id_eq;
    assign verdict.online   = (age < timeout_ext);

endmodule

// ----- sv/device_presence_table_core.sv -----
// top level of the device presence table: scan sequencer, config register
// and stream ports; depends on dpt_pkg, dpt_store and dpt_match
//
// A table of TABLE_ENTRIES device records (64-bit id, IPv4 address, port,
// last-seen stamp). Each input transfer is either a lookup (tuser 0) or a
// register/refresh (tuser 1). The sequencer reads one record per cycle out
// of a single-port-read memory and runs it through one shared compare unit;
// the scan stops at the first qualifying slot. The scan of an item runs
// slot by slot through the one memory read port, from slot zero up to
// slot TABLE_ENTRIES - 1 at most.
// A register transfer writes the slot in the cycle it is found. The block
// takes no new item until the result has moved into the output register;
// a result still waiting on the output does not hold up the next scan.
// After reset the block sweeps the memory once to mark every slot empty,
// and s_tready stays low throughout the sweep; timeout writes on
// the config channel are taken at any time the block is idle.
module device_presence_table_core #(
    parameter int TABLE_ENTRIES = dpt_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // config channel: online timeout in seconds
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dpt_pkg::TIMEOUT_W-1:0]    cfg_data,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] dev_id_high, [63:32] dev_id_low, [95:64] peer_addr,
    // [111:96] peer_port, [143:112] current time in seconds
    input  logic [143:0]                     s_tdata,
    // [0] func
    input  logic                             s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [4:0] slot, [36:5] entry_addr, [52:37] entry_port, [55:53] zero
    output logic [55:0]                      m_tdata,
    // [0] found, [1] online
    output logic [1:0]                       m_tuser
);
    import dpt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // captured item
    logic                 func_reg;
    logic [ID_W-1:0]      id_high_reg;
    logic [ID_W-1:0]      id_low_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [PORT_W-1:0]    port_reg;
    logic [TIME_W-1:0]    now_reg;

    // pending result
    logic                 res_found_reg, res_found_next;
    logic                 res_online_reg, res_online_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic [PORT_W-1:0]    res_port_reg, res_port_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic                 m_found_reg, m_found_next;
    logic                 m_online_reg, m_online_next;
    logic [SLOT_W-1:0]    m_slot_reg, m_slot_next;
    logic [ADDR_W-1:0]    m_addr_reg, m_addr_next;
    logic [PORT_W-1:0]    m_port_reg, m_port_next;

    logic                 s_accept;
    logic                 out_free;
    logic                 hit;

    logic                 wr_en;
    logic [IDX_W-1:0]     rd_addr;
    rec_t                 wr_data;
    rec_t                 rd_data;
    match_t               verdict;

    // timeout only changes between scans
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            timeout_reg <= cfg_data;
        end
    end

    // item capture, payload only
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            func_reg    <= s_tuser;
            id_high_reg <= s_tdata[31:0];
            id_low_reg  <= s_tdata[63:32];
            addr_reg    <= s_tdata[95:64];
            port_reg    <= s_tdata[111:96];
            now_reg     <= s_tdata[143:112];
        end
    end

    dpt_store #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dpt_match u_match (
        .rec      (rd_data),
        .id_high  (id_high_reg),
        .id_low   (id_low_reg),
        .now_secs (now_reg),
        .timeout  (timeout_reg),
        .verdict  (verdict)
    );

    // record under test qualifies for the current function
    assign hit = (func_reg == FUNC_REGISTER) ? verdict.reg_hit : verdict.look_hit;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        res_found_next  = res_found_reg;
        res_online_next = res_online_reg;
        res_slot_next   = res_slot_reg;
        res_addr_next   = res_addr_reg;
        res_port_next   = res_port_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_found_next    = m_found_reg;
        m_online_next   = m_online_reg;
        m_slot_next     = m_slot_reg;
        m_addr_next     = m_addr_reg;
        m_port_next     = m_port_reg;
        wr_en           = 1'b0;
        rd_addr         = idx_reg + IDX_W'(1);
        wr_data         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                // zero record: stamp zero marks the slot empty
                wr_en    = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_addr = '0;
                if (s_accept)
                begin
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // rd_data holds slot idx_reg; slot idx_reg+1 is being read
                if (hit)
                begin
                    res_found_next = 1'b1;
                    res_slot_next  = SLOT_W'(idx_reg);
                    if (func_reg == FUNC_REGISTER)
                    begin
                        wr_en           = 1'b1;
                        wr_data.id_high = id_high_reg;
                        wr_data.id_low  = id_low_reg;
                        wr_data.addr    = addr_reg;
                        wr_data.port    = port_reg;
                        wr_data.stamp   = now_reg;
                        res_online_next = (timeout_reg != '0);
                        res_addr_next   = addr_reg;
                        res_port_next   = port_reg;
                    end
                    else
                    begin
                        res_online_next = verdict.online;
                        res_addr_next   = rd_data.addr;
                        res_port_next   = rd_data.port;
                    end
                    state_next = S_OUT;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    // nothing qualifies: all-zero result
                    res_found_next  = 1'b0;
                    res_online_next = 1'b0;
                    res_slot_next   = '0;
                    res_addr_next   = '0;
                    res_port_next   = '0;
                    state_next      = S_OUT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_found_next  = res_found_reg;
                    m_online_next = res_online_reg;
                    m_slot_next   = res_slot_reg;
                    m_addr_next   = res_addr_reg;
                    m_port_next   = res_port_reg;
                    idx_next      = '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
            res_found_reg  <= 1'b0;
            res_online_reg <= 1'b0;
            res_slot_reg   <= '0;
            res_addr_reg   <= '0;
            res_port_reg   <= '0;
            m_found_reg    <= 1'b0;
            m_online_reg   <= 1'b0;
            m_slot_reg     <= '0;
            m_addr_reg     <= '0;
            m_port_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
            res_found_reg  <= res_found_next;
            res_online_reg <= res_online_next;
            res_slot_reg   <= res_slot_next;
            res_addr_reg   <= res_addr_next;
            res_port_reg   <= res_port_next;
            m_found_reg    <= m_found_next;
            m_online_reg   <= m_online_next;
            m_slot_reg     <= m_slot_next;
            m_addr_reg     <= m_addr_next;
            m_port_reg     <= m_port_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_port_reg, m_addr_reg, m_slot_reg};
    assign m_tuser  = {m_online_reg, m_found_reg};

`ifndef SYNTH
    // the scan only ever writes the table for a register item
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && state_reg == S_SCAN) |-> (func_reg == FUNC_REGISTER))
        else $error("table write during a lookup scan");

    // no input transfer while the clearing sweep runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("input ready during clearing sweep");

    // every accepted item starts a scan at slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == S_SCAN && idx_reg == '0))
        else $error("accepted item did not start a scan");

    // a new result appears only out of the result hold state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result loaded outside the result hold state");

    // a miss carries an all-zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_found_reg) |->
            (!m_online_reg && m_slot_reg == '0 && m_addr_reg == '0 && m_port_reg == '0))
        else $error("miss result with nonzero fields");
`endif

endmodule

// ----- sim/device_presence_table_core_tb.sv -----
// self-checking testbench of device_presence_table_core: directed and random
// lookups and registrations checked against a predictor of the slot table
// depends on dpt_pkg and device_presence_table_core
module device_presence_table_core_tb;

    import dpt_pkg::*;

    localparam int NUM_SLOTS = DEF_TABLE_ENTRIES;

    // one input item, fields as carried on s_tdata and s_tuser
    typedef struct packed {
        logic              func;
        logic [ID_W-1:0]   id_high;
        logic [ID_W-1:0]   id_low;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] now;
    } presence_item_t;

    // one result item, fields as carried on m_tdata and m_tuser
    typedef struct packed {
        logic              found;
        logic              online;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } presence_reply_t;

    // shadow copy of the table; works out the reply of each accepted item
    class presence_scoreboard;
        logic [ID_W-1:0]      id_high_q [NUM_SLOTS];
        logic [ID_W-1:0]      id_low_q  [NUM_SLOTS];
        logic [ADDR_W-1:0]    addr_q    [NUM_SLOTS];
        logic [PORT_W-1:0]    port_q    [NUM_SLOTS];
        logic [TIME_W-1:0]    stamp_q   [NUM_SLOTS];
        logic [TIMEOUT_W-1:0] timeout;
        presence_reply_t      expected_replies [$];
        int                   errors;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                id_high_q[i] = '0;
                id_low_q[i]  = '0;
                addr_q[i]    = '0;
                port_q[i]    = '0;
                stamp_q[i]   = '0;
            end
            timeout = TIMEOUT_RESET;
            errors  = 0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        // scan in slot order, first qualifying slot wins
        function void record_request(presence_item_t it);
            presence_reply_t   rep;
            logic [TIME_W-1:0] age;
            logic              same;
            rep = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                age  = it.now - stamp_q[i];
                same = (id_high_q[i] == it.id_high) && (id_low_q[i] == it.id_low);
                if (it.func == FUNC_REGISTER)
                begin
                    if (stamp_q[i] == '0 || age > TIME_W'(timeout) || same)
                    begin
                        id_high_q[i] = it.id_high;
                        id_low_q[i]  = it.id_low;
                        addr_q[i]    = it.addr;
                        port_q[i]    = it.port;
                        stamp_q[i]   = it.now;
                        rep.found    = 1'b1;
                        rep.online   = (timeout != '0);
                        rep.slot     = SLOT_W'(i);
                        rep.addr     = it.addr;
                        rep.port     = it.port;
                        break;
                    end
                end
                else if (stamp_q[i] != '0 && same)
                begin
                    rep.found  = 1'b1;
                    rep.online = (age < TIME_W'(timeout));
                    rep.slot   = SLOT_W'(i);
                    rep.addr   = addr_q[i];
                    rep.port   = port_q[i];
                    break;
                end
            end
            expected_replies.push_back(rep);
        endfunction

        function void check_reply(logic [55:0] tdata, logic [1:0] tuser);
            presence_reply_t got;
            presence_reply_t exp;
            got.found  = tuser[0];
            got.online = tuser[1];
            got.slot   = tdata[4:0];
            got.addr   = tdata[36:5];
            got.port   = tdata[52:37];
            if (expected_replies.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected reply: found %0b online %0b slot %0d addr %h port %h",
                             got.found, got.online, got.slot, got.addr, got.port);
                return;
            end
            exp = expected_replies.pop_front();
            if (got.found !== exp.found || got.online !== exp.online ||
                got.slot !== exp.slot || got.addr !== exp.addr || got.port !== exp.port)
            begin
                errors++;
                if (errors <= 10)
                    $display({"reply mismatch: exp found %0b online %0b slot %0d addr %h ",
                              "port %h, got found %0b online %0b slot %0d addr %h port %h"},
                             exp.found, exp.online, exp.slot, exp.addr, exp.port,
                             got.found, got.online, got.slot, got.addr, got.port);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TIMEOUT_W-1:0] cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [143:0]         s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [55:0]          m_tdata;
    logic [1:0]           m_tuser;

    presence_scoreboard   sb;

    // idling percentages of the current phase
    int                   gap_pct   = 0;
    int                   stall_pct = 0;

    // stimulus state: running clock, timeout in force, pool of device ids
    logic [TIME_W-1:0]    cur_time;
    logic [TIMEOUT_W-1:0] cur_timeout;
    logic [63:0]          id_pool [48];

    device_presence_table_core #(
        .TABLE_ENTRIES (NUM_SLOTS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous bound, well above the slowest correct run
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side: check each transfer, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reply(m_tdata, m_tuser);
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // valid is not lowered at the end, so back-to-back items keep it high
    task automatic send_item(input presence_item_t it);
        // sender idles cycle by cycle before offering the item
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {it.now, it.port, it.addr, it.id_low, it.id_high};
        do
            @(posedge clk);
        while (!s_tready);
        sb.record_request(it);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        sb.timeout  = value;
        cur_timeout = value;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    function automatic presence_item_t make_item(logic func, logic [31:0] hi, logic [31:0] lo,
                                                 logic [31:0] addr, logic [15:0] port,
                                                 logic [31:0] now);
        presence_item_t it;
        it.func    = func;
        it.id_high = hi;
        it.id_low  = lo;
        it.addr    = addr;
        it.port    = port;
        it.now     = now;
        return it;
    endfunction

    // mostly small steps of the clock, with jumps past the timeout, steps
    // back (stamps in the future) and leaps anywhere in the 32-bit range
    function automatic presence_item_t random_item();
        presence_item_t it;
        int             r;
        logic [63:0]    id;
        r = $urandom_range(0, 99);
        if (r < 70)
            cur_time = cur_time + $urandom_range(0, 3);
        else if (r < 88)
            cur_time = cur_time + $urandom_range(0, 2 * int'(cur_timeout) + 2);
        else if (r < 94)
            cur_time = cur_time - $urandom_range(1, 100);
        else
            cur_time = $urandom;
        if (cur_time == '0)
            cur_time = 1;
        id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : id_pool[$urandom_range(0, 47)];
        it.func    = ($urandom_range(0, 99) < 55) ? FUNC_REGISTER : FUNC_LOOKUP;
        it.id_high = id[63:32];
        it.id_low  = id[31:0];
        it.addr    = $urandom;
        it.port    = PORT_W'($urandom);
        it.now     = cur_time;
        if (it.func == FUNC_LOOKUP && $urandom_range(0, 99) < 15)
        begin
            it.now = $urandom;
            if (it.now == '0)
                it.now = 1;
        end
        return it;
    endfunction

    initial
    begin
        presence_item_t       directed [$];
        logic [TIMEOUT_W-1:0] phase_timeout [8];

        sb = new();
        cur_time    = 32'd1000;
        cur_timeout = TIMEOUT_RESET;
        id_pool[0]  = '0;
        id_pool[1]  = '1;
        for (int i = 2; i < 48; i++)
            id_pool[i] = {$urandom, $urandom};

        phase_timeout[0] = 16'hFFFF;
        phase_timeout[1] = 16'd0;
        phase_timeout[2] = TIMEOUT_RESET;
        phase_timeout[3] = 16'd7;
        phase_timeout[4] = 16'd1;
        phase_timeout[5] = 16'd300;
        phase_timeout[6] = TIMEOUT_W'($urandom_range(2, 65534));
        phase_timeout[7] = 16'd2;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset timeout of 60
        // id zero on an empty table must not match
        directed.push_back(make_item(FUNC_LOOKUP,   '0, '0, 32'h1, 16'h1, 32'd1));
        directed.push_back(make_item(FUNC_REGISTER, '0, '0, '0, '0, 32'd100));
        directed.push_back(make_item(FUNC_LOOKUP,   '0, '0, '0, '0, 32'd100));
        directed.push_back(make_item(FUNC_REGISTER, '1, '1, '1, '1, 32'd100));
        // age equal to the timeout: found but offline, one less: online
        directed.push_back(make_item(FUNC_LOOKUP,   '1, '1, '0, '0, 32'd160));
        directed.push_back(make_item(FUNC_LOOKUP,   '1, '1, '0, '0, 32'd159));
        // slot 0 is now expired and gets reused
        directed.push_back(make_item(FUNC_REGISTER, 32'hA5A5_0001, 32'h5A5A_0001,
                                     32'hC0A8_0101, 16'd5000, 32'd161));
        // refresh of an existing id keeps its slot
        directed.push_back(make_item(FUNC_REGISTER, '1, '1, 32'h0A00_0001, 16'd80, 32'd170));
        directed.push_back(make_item(FUNC_REGISTER, 32'h0000_0002, 32'h8000_0000,
                                     32'h7F00_0001, 16'h8000, 32'd170));
        // stamp in the future reads as very old
        directed.push_back(make_item(FUNC_LOOKUP,   32'hA5A5_0001, 32'h5A5A_0001,
                                     '0, '0, 32'd50));
        directed.push_back(make_item(FUNC_REGISTER, 32'h1234_5678, 32'h9ABC_DEF0,
                                     32'h5555_AAAA, 16'h00FF, 32'd50));
        // zero time stores an empty stamp, so the id cannot be found after
        directed.push_back(make_item(FUNC_REGISTER, 32'hDEAD_BEEF, 32'h0BAD_F00D,
                                     32'hAAAA_5555, 16'hFF00, 32'd0));
        directed.push_back(make_item(FUNC_LOOKUP,   32'hDEAD_BEEF, 32'h0BAD_F00D,
                                     '0, '0, 32'd0));
        // half of the id matching is no match
        directed.push_back(make_item(FUNC_LOOKUP,   '1, '0, '0, '0, 32'd170));
        directed.push_back(make_item(FUNC_LOOKUP,   '0, '1, '0, '0, 32'd170));
        // top of the time range
        directed.push_back(make_item(FUNC_REGISTER, 32'hFFFF_0000, 32'h0000_FFFF,
                                     32'h8000_0001, 16'h7FFF, 32'hFFFF_FFFF));
        directed.push_back(make_item(FUNC_LOOKUP,   32'hFFFF_0000, 32'h0000_FFFF,
                                     '0, '0, 32'hFFFF_FFFF));
        directed.push_back(make_item(FUNC_LOOKUP,   32'hFFFF_0000, 32'h0000_FFFF,
                                     '0, '0, 32'd1));
        foreach (directed[i])
            send_item(directed[i]);
        drain();

        // random phases: each writes a new timeout while idle, then cycles
        // through no idling, sender gaps, receiver stalls and both
        for (int p = 0; p < 8; p++)
        begin
            write_timeout(phase_timeout[p]);
            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 45; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 45; end
                default: begin gap_pct = 8; stall_pct = 8; end
            endcase
            repeat (100)
                send_item(random_item());
            drain();
        end

        // let a late or spurious reply show up
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
